### rtl/core/slt_pkg.sv
package slt_pkg;

  // sequence space and table size
  localparam int SEQ_MODULUS = 32768;
  localparam int NEIGHBORS   = 8;

  localparam int NB_IN_W = 3;
  localparam int SEQ_W   = 16;
  localparam int IV_W    = 32;
  localparam int NB_W    = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;

  localparam logic [SEQ_W-1:0] SEQ_SPECIAL = 16'hffff;
  localparam logic [SEQ_W-1:0] SEQ_HALF    = SEQ_W'(SEQ_MODULUS / 2);
  localparam logic [SEQ_W-1:0] SEQ_LAST    = SEQ_W'(SEQ_MODULUS - 1);
  localparam logic [SEQ_W-1:0] ROUNDS_MAX  = 16'hffff;
  localparam logic [IV_W-1:0]  SEQ_MOD_IV  = IV_W'(SEQ_MODULUS);

  typedef enum logic [2:0] {
    V_INORDER = 3'd0,
    V_OLD     = 3'd1,
    V_WRAP    = 3'd2,
    V_LOSS    = 3'd3,
    V_SPECIAL = 3'd4
  } verdict_e;

  // one table entry per neighbor
  typedef struct packed {
    logic [SEQ_W-1:0] expected;
    logic [SEQ_W-1:0] last_clean;
    logic [SEQ_W-1:0] rounds;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // result of one table update
  typedef struct packed {
    entry_t          next;
    verdict_e        verdict;
    logic [IV_W-1:0] interval;
  } upd_t;

  // fold an out-of-range neighbor index back into the table
  function automatic logic [NB_W-1:0] nb_index(input logic [NB_IN_W-1:0] nb);
    logic [8:0] v;
    v = {6'd0, nb};
    for (int k = 0; k < 8; k++) begin
      if (v >= 9'(NEIGHBORS)) begin
        v = v - 9'(NEIGHBORS);
      end
    end
    return v[NB_W-1:0];
  endfunction

endpackage

### rtl/core/slt_if.sv
// input channel: neighbor and received sequence number
interface slt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  neighbor;
  logic [15:0] seq;

  modport source (output valid, output neighbor, output seq, input ready);
  modport sink   (input valid, input neighbor, input seq, output ready);
endinterface

// output channel: verdict and loss interval
interface slt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [31:0] loss_interval;

  modport source (output valid, output verdict, output loss_interval, input ready);
  modport sink   (input valid, input verdict, input loss_interval, output ready);
endinterface

### rtl/core/slt_ram.sv
module slt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/slt_update.sv
module slt_update (
  input  slt_pkg::entry_t             cur_i,
  input  logic [slt_pkg::SEQ_W-1:0]   seq_i,
  output slt_pkg::upd_t               upd_o
);
  import slt_pkg::*;

  logic [SEQ_W-1:0] e;
  logic [SEQ_W-1:0] ahead;
  logic [SEQ_W-1:0] behind;
  logic             is_next;
  logic [IV_W-1:0]  iv;
  entry_t           loss_entry;

  assign e      = cur_i.expected;
  assign ahead  = seq_i - e;
  assign behind = e - seq_i;
  assign is_next = {1'b0, seq_i} == ({1'b0, e} + 17'd1);

  // interval since the last loss, taken before the update
  assign iv = SEQ_MOD_IV * {16'd0, cur_i.rounds}
            + ({16'd0, e} - {16'd0, cur_i.last_clean});

  always_comb begin
    loss_entry.expected   = seq_i;
    loss_entry.last_clean = seq_i;
    loss_entry.rounds     = '0;
  end

  // classify and compute the new entry
  always_comb begin
    upd_o.next     = cur_i;
    upd_o.verdict  = V_OLD;
    upd_o.interval = '0;
    if (seq_i == SEQ_SPECIAL) begin
      upd_o.verdict = V_SPECIAL;
    end else if (seq_i == e) begin
      upd_o.verdict = V_OLD;
    end else if (seq_i > e) begin
      if (ahead > SEQ_HALF) begin
        upd_o.verdict = V_OLD;
      end else if (is_next) begin
        upd_o.verdict       = V_INORDER;
        upd_o.next.expected = seq_i;
      end else begin
        upd_o.verdict  = V_LOSS;
        upd_o.next     = loss_entry;
        upd_o.interval = iv;
      end
    end else begin
      if (behind < SEQ_HALF) begin
        upd_o.verdict = V_OLD;
      end else if (e == SEQ_LAST && seq_i == '0) begin
        upd_o.verdict       = V_WRAP;
        upd_o.next.expected = '0;
        if (cur_i.rounds != ROUNDS_MAX) begin
          upd_o.next.rounds = cur_i.rounds + 16'd1;
        end
      end else begin
        upd_o.verdict  = V_LOSS;
        upd_o.next     = loss_entry;
        upd_o.interval = iv;
      end
    end
  end

endmodule

### rtl/core/seq_loss_tracker_top.sv
// channel | dir | signals                          | meaning
// in_i    | in  | valid ready neighbor[3] seq[16]  | received packet per neighbor
// out_o   | out | valid ready verdict[3] iv[32]    | classification and loss interval
//
// one item per cycle unless output stalls; update stage feeds the result register
// the neighbor table is read on input transfer and written as the item leaves update;
// the last write is forwarded, so back-to-back items to one neighbor see fresh state
// reset clears per-entry valid bits at once; an entry not yet written reads as zero
// a stalled result register holds the update stage, which in turn holds the input
module seq_loss_tracker_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  slt_in_if.sink    in_i,
  slt_out_if.source out_o
);
  import slt_pkg::*;

  logic                s1_vld_q;
  logic [NB_W-1:0]     s1_idx_q;
  logic [SEQ_W-1:0]    s1_seq_q;
  logic                s1_adv;
  logic                in_xfer;
  logic [NB_W-1:0]     in_idx;

  logic [NEIGHBORS-1:0] ent_vld_q;
  logic                 wb_vld_q;
  logic [NB_W-1:0]      wb_idx_q;
  entry_t               wb_data_q;

  logic [ENTRY_W-1:0]   rdata;
  entry_t               cur;
  upd_t                 upd;
  logic                 we;

  logic                 out_vld_q;
  logic [2:0]           out_verdict_q;
  logic [IV_W-1:0]      out_iv_q;

  // handshake control
  assign in_xfer    = in_i.valid && in_i.ready;
  assign s1_adv     = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || s1_adv;
  assign in_idx     = nb_index(in_i.neighbor);

  // entry table
  slt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NEIGHBORS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (s1_idx_q),
    .wdata_i (upd.next),
    .re_i    (in_xfer),
    .raddr_i (in_idx),
    .rdata_o (rdata)
  );

  // update stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_idx_q <= in_idx;
      s1_seq_q <= in_i.seq;
    end
  end

  // forward the last write, unwritten entries read as zero
  always_comb begin
    if (wb_vld_q && wb_idx_q == s1_idx_q) begin
      cur = wb_data_q;
    end else if (ent_vld_q[s1_idx_q]) begin
      cur = entry_t'(rdata);
    end else begin
      cur = '0;
    end
  end

  slt_update u_update (
    .cur_i (cur),
    .seq_i (s1_seq_q),
    .upd_o (upd)
  );

  assign we = s1_adv && (upd.verdict != V_SPECIAL);

  // write-back tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      wb_vld_q  <= 1'b0;
    end else if (we) begin
      ent_vld_q[s1_idx_q] <= 1'b1;
      wb_vld_q            <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      wb_idx_q  <= s1_idx_q;
      wb_data_q <= upd.next;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_verdict_q <= upd.verdict;
      out_iv_q      <= upd.interval;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.verdict       = out_verdict_q;
  assign out_o.loss_interval = out_iv_q;

  // an accepted item always reaches the update stage
  a_xfer_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> s1_vld_q)
    else $error("accepted item did not reach update stage");

  // input backs up only when both stages are full and the output stalls
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_vld_q && out_vld_q && !out_o.ready))
    else $error("input stalled without a full pipeline");

  // loss interval is zero unless a loss is reported
  a_iv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.verdict != V_LOSS) |-> (out_o.loss_interval == '0))
    else $error("nonzero interval without loss");

endmodule

### verif/tb_seq_loss_tracker_top.sv
module tb_seq_loss_tracker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slt_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int LONG_HOLD    = 60;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 190;
  localparam int BURST_ITEMS  = 70;
  localparam int PROBE_COUNT  = 25;

  // expected outcome of one packet
  typedef struct packed {
    verdict_e         verdict;
    logic [IV_W-1:0]  interval;
  } result_t;

  // one row of the directed table
  typedef struct packed {
    logic [NB_IN_W-1:0] nb;
    logic [SEQ_W-1:0]   seq;
    logic               fixed;
    verdict_e           verdict;
    logic [IV_W-1:0]    interval;
  } probe_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  slt_in_if  in_if ();
  slt_out_if out_if ();

  seq_loss_tracker_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // per-neighbor shadow of the loss table
  logic [SEQ_W-1:0] next_seq      [NEIGHBORS];
  logic [SEQ_W-1:0] stretch_start [NEIGHBORS];
  logic [SEQ_W-1:0] clean_wraps   [NEIGHBORS];

  result_t pending_verdicts [$];
  probe_t  probes [PROBE_COUNT];

  int unsigned bad_results   = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_requests = 0;

  // table row riding along with the transfer on the input channel
  logic            row_fixed;
  verdict_e        row_verdict;
  logic [IV_W-1:0] row_interval;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // classify one packet and update the shadow table
  function automatic result_t classify_packet(input logic [NB_IN_W-1:0] nb_raw,
                                              input logic [SEQ_W-1:0] s);
    int unsigned      idx;
    logic [SEQ_W-1:0] e;
    logic             is_loss;
    result_t          res;
    idx     = int'(nb_raw) % NEIGHBORS;
    e       = next_seq[idx];
    is_loss = 1'b0;
    res.interval = '0;
    if (s == SEQ_SPECIAL) begin
      res.verdict = V_SPECIAL;
    end else if (s == e) begin
      res.verdict = V_OLD;
    end else if (s > e) begin
      if (s - e > SEQ_HALF) begin
        res.verdict = V_OLD;
      end else if ({1'b0, s} == {1'b0, e} + 17'd1) begin
        next_seq[idx] = s;
        res.verdict   = V_INORDER;
      end else begin
        is_loss = 1'b1;
      end
    end else begin
      if (e - s < SEQ_HALF) begin
        res.verdict = V_OLD;
      end else if (e == SEQ_LAST && s == '0) begin
        next_seq[idx] = '0;
        if (clean_wraps[idx] != ROUNDS_MAX) begin
          clean_wraps[idx] = clean_wraps[idx] + 16'd1;
        end
        res.verdict = V_WRAP;
      end else begin
        is_loss = 1'b1;
      end
    end
    // a loss reports the stretch length and restarts it at the new number
    if (is_loss) begin
      res.verdict  = V_LOSS;
      res.interval = SEQ_MOD_IV * IV_W'(clean_wraps[idx])
                     + IV_W'(e) - IV_W'(stretch_start[idx]);
      next_seq[idx]      = s;
      stretch_start[idx] = s;
      clean_wraps[idx]   = '0;
    end
    return res;
  endfunction

  // predict on input transfers, check on output transfers, watch for hangs
  always @(posedge clk_i) begin : scoreboard
    result_t predicted;
    result_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        predicted = classify_packet(in_if.neighbor, in_if.seq);
        if (row_fixed) begin
          predicted.verdict  = row_verdict;
          predicted.interval = row_interval;
        end
        pending_verdicts.push_back(predicted);
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_verdicts.size() == 0) begin
          if (bad_results < 10) begin
            $display("%0t: unexpected result verdict=%0d interval=%0d",
                     $realtime, out_if.verdict, out_if.loss_interval);
          end
          bad_results++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_if.verdict !== want.verdict || out_if.loss_interval !== want.interval) begin
            if (bad_results < 10) begin
              $display("%0t: mismatch verdict exp=%0d act=%0d interval exp=%0d act=%0d",
                       $realtime, want.verdict, out_if.verdict,
                       want.interval, out_if.loss_interval);
            end
            bad_results++;
          end
        end
      end
      // watchdog on cycles without any transfer
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  initial begin : receiver
    int unsigned hold_left;
    int unsigned holds_seen;
    hold_left    = 0;
    holds_seen   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // offer one packet, idling first at the current rate; returns at a falling edge
  task automatic send_packet(input logic [NB_IN_W-1:0] nb, input logic [SEQ_W-1:0] s,
                             input logic fixed, input verdict_e v,
                             input logic [IV_W-1:0] iv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.neighbor <= nb;
    in_if.seq      <= s;
    row_fixed      <= fixed;
    row_verdict    <= v;
    row_interval   <= iv;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // switch idle rates with the input channel quiet
  task automatic set_phase(input int unsigned idle_pct, input int unsigned stall,
                           input logic long_hold);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    if (long_hold) begin
      hold_requests++;
    end
    @(negedge clk_i);
  endtask

  // mostly in-order runs per neighbor, with duplicates, gaps, wraps and noise
  task automatic send_traffic(input int unsigned count);
    logic [NB_IN_W-1:0] nb;
    logic [SEQ_W-1:0]   e;
    logic [SEQ_W-1:0]   s;
    int unsigned        kind;
    nb = '0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        nb = NB_IN_W'($urandom_range(0, 7));
      end
      e    = next_seq[int'(nb) % NEIGHBORS];
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        s = (e == SEQ_LAST) ? '0 : e + 16'd1;
      end else if (kind < 63) begin
        s = e - SEQ_W'($urandom_range(0, 64));
      end else if (kind < 71) begin
        s = e + SEQ_W'($urandom_range(2, 40));
      end else if (kind < 77) begin
        s = SEQ_LAST - SEQ_W'($urandom_range(0, 12));
      end else if (kind < 81) begin
        s = SEQ_SPECIAL;
      end else begin
        s = SEQ_W'($urandom_range(0, 65535));
      end
      send_packet(nb, s, 1'b0, V_INORDER, '0);
    end
  endtask

  initial begin : main
    in_if.valid    = 1'b0;
    in_if.neighbor = '0;
    in_if.seq      = '0;
    row_fixed      = 1'b0;
    row_verdict    = V_INORDER;
    row_interval   = '0;
    rst_ni         = 1'b0;
    for (int i = 0; i < NEIGHBORS; i++) begin
      next_seq[i]      = '0;
      stretch_start[i] = '0;
      clean_wraps[i]   = '0;
    end

    // directed rows: neighbor, seq, fixed expectation, verdict, interval
    probes = '{
      '{3'd0, 16'hffff, 1'b1, V_SPECIAL, 32'd0},  // reserved value
      '{3'd0, 16'd0,    1'b1, V_OLD,     32'd0},  // equal to reset state
      '{3'd0, 16'd1,    1'b1, V_INORDER, 32'd0},
      '{3'd0, 16'd2,    1'b1, V_INORDER, 32'd0},
      '{3'd0, 16'd2,    1'b1, V_OLD,     32'd0},  // duplicate
      '{3'd0, 16'd1,    1'b1, V_OLD,     32'd0},  // slightly behind
      '{3'd0, 16'd16387, 1'b1, V_OLD,    32'd0},  // ahead by more than half
      '{3'd0, 16'd16386, 1'b1, V_LOSS,   32'd2},  // ahead by exactly half
      '{3'd7, 16'd65534, 1'b1, V_OLD,    32'd0},  // top of range
      '{3'd7, 16'd16384, 1'b1, V_LOSS,   32'd0},
      '{3'd7, 16'd32767, 1'b1, V_LOSS,   32'd0},
      '{3'd7, 16'd0,    1'b1, V_WRAP,    32'd0},  // clean wrap
      '{3'd7, 16'd1,    1'b1, V_INORDER, 32'd0},
      '{3'd7, 16'd5,    1'b1, V_LOSS,    32'd2},  // loss after a round, negative diff
      '{3'd7, 16'hffff, 1'b1, V_SPECIAL, 32'd0},
      '{3'd7, 16'd6,    1'b1, V_INORDER, 32'd0},
      '{3'd3, 16'd16384, 1'b1, V_LOSS,   32'd0},
      '{3'd3, 16'd32767, 1'b1, V_LOSS,   32'd0},
      '{3'd3, 16'd40000, 1'b1, V_LOSS,   32'd0},  // above the modulus
      '{3'd3, 16'd40001, 1'b1, V_INORDER, 32'd0},
      '{3'd3, 16'd65534, 1'b1, V_OLD,    32'd0},
      '{3'd3, 16'd0,    1'b1, V_LOSS,    32'd1},  // behind, not a wrap
      '{3'd5, 16'd0,    1'b1, V_OLD,     32'd0},
      '{3'd6, 16'd1,    1'b0, V_INORDER, 32'd0},
      '{3'd6, 16'd3,    1'b0, V_INORDER, 32'd0}
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part, back to back
    set_phase(0, 0, 1'b0);
    for (int i = 0; i < PROBE_COUNT; i++) begin
      send_packet(probes[i].nb, probes[i].seq, probes[i].fixed,
                  probes[i].verdict, probes[i].interval);
    end

    // random traffic under each idle pattern
    set_phase(0, 0, 1'b0);
    send_traffic(PHASE_ITEMS);
    set_phase(62, 0, 1'b0);
    send_traffic(PHASE_ITEMS);
    set_phase(0, 62, 1'b0);
    send_traffic(PHASE_ITEMS);
    set_phase(17, 17, 1'b0);
    send_traffic(PHASE_ITEMS);

    // long receiver hold-off while the sender keeps pushing
    set_phase(0, 0, 1'b1);
    send_traffic(BURST_ITEMS);

    in_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (bad_results == 0 && pending_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
